[rtl/otq_pkg.sv]
`default_nettype none

package otq_pkg;

   localparam int TIME_W     = 63;
   localparam int PERIOD_W   = 40;
   localparam int MIN_LEAD_W = 20;
   localparam int HANDLE_W   = 4;
   localparam int KIND_W     = 2;

   localparam logic [MIN_LEAD_W-1:0] MIN_LEAD_RESET = 20'd100;

   localparam logic MODE_ADD  = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   localparam logic [KIND_W-1:0] KIND_ADDED   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FIRED   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;
   localparam logic [KIND_W-1:0] KIND_FULL    = 2'd3;

   typedef struct packed {
      logic                mode;
      logic [TIME_W-1:0]   expire_at;
      logic [PERIOD_W-1:0] period_us;
      logic [TIME_W-1:0]   now_us;
   } otq_req_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [HANDLE_W-1:0] handle;
      logic                arm_valid;
      logic [TIME_W-1:0]   arm_delay_us;
      logic [TIME_W-1:0]   next_deadline;
      logic                last;
   } otq_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD_SCAN,
      ST_ADD_CALC,
      ST_ADD_EMIT,
      ST_FULL_EMIT,
      ST_TICK_SCAN,
      ST_FIRE,
      ST_SUM_SCAN,
      ST_SUM_CALC,
      ST_SUM_EMIT
   } otq_state_type;

   // Which slots take part in a scan for the earliest deadline.
   typedef enum logic [1:0] {
      SCAN_USED,
      SCAN_MARK,
      SCAN_DUE
   } otq_scan_sel_type;

   typedef enum logic [2:0] {
      EMIT_NONE,
      EMIT_ADD,
      EMIT_FULL,
      EMIT_FIRE,
      EMIT_SUM
   } otq_emit_type;

   typedef struct packed {
      logic             capture;
      logic             scan_start;
      otq_scan_sel_type scan_sel;
      logic             add_commit;
      logic             sum_calc;
      otq_emit_type     emit;
   } otq_cmd_type;

   typedef struct packed {
      logic scan_busy;
      logic found;
      logic full;
      logic out_free;
   } otq_status_type;

endpackage

`default_nettype wire

[rtl/otq_ctrl.sv]
`default_nettype none

module otq_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_mode,
   output logic                        req_stall,
   input  wire otq_pkg::otq_status_type status,
   output otq_pkg::otq_cmd_type        cmd
);

   otq_pkg::otq_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= otq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         otq_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_mode == otq_pkg::MODE_TICK) ? otq_pkg::ST_TICK_SCAN
                                                           : otq_pkg::ST_ADD_SCAN;
            end
         end
         otq_pkg::ST_ADD_SCAN: begin
            if (!status.scan_busy) begin
               state_in = status.full ? otq_pkg::ST_FULL_EMIT : otq_pkg::ST_ADD_CALC;
            end
         end
         otq_pkg::ST_ADD_CALC: begin
            state_in = otq_pkg::ST_ADD_EMIT;
         end
         otq_pkg::ST_ADD_EMIT, otq_pkg::ST_FULL_EMIT, otq_pkg::ST_SUM_EMIT: begin
            if (status.out_free) begin
               state_in = otq_pkg::ST_IDLE;
            end
         end
         otq_pkg::ST_TICK_SCAN: begin
            if (!status.scan_busy) begin
               state_in = status.found ? otq_pkg::ST_FIRE : otq_pkg::ST_SUM_SCAN;
            end
         end
         otq_pkg::ST_FIRE: begin
            if (status.out_free) begin
               state_in = otq_pkg::ST_TICK_SCAN;
            end
         end
         otq_pkg::ST_SUM_SCAN: begin
            if (!status.scan_busy) begin
               state_in = otq_pkg::ST_SUM_CALC;
            end
         end
         otq_pkg::ST_SUM_CALC: begin
            state_in = otq_pkg::ST_SUM_EMIT;
         end
         default: begin
            state_in = otq_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.scan_sel   = otq_pkg::SCAN_USED;
      cmd.emit       = otq_pkg::EMIT_NONE;
      req_stall      = (state_ff != otq_pkg::ST_IDLE);
      case (state_ff)
         otq_pkg::ST_IDLE: begin
            cmd.capture    = req_valid;
            cmd.scan_start = req_valid;
            cmd.scan_sel   = (req_mode == otq_pkg::MODE_TICK) ? otq_pkg::SCAN_MARK
                                                              : otq_pkg::SCAN_USED;
         end
         otq_pkg::ST_ADD_CALC: begin
            cmd.add_commit = 1'b1;
         end
         otq_pkg::ST_ADD_EMIT: begin
            if (status.out_free) begin
               cmd.emit = otq_pkg::EMIT_ADD;
            end
         end
         otq_pkg::ST_FULL_EMIT: begin
            if (status.out_free) begin
               cmd.emit = otq_pkg::EMIT_FULL;
            end
         end
         otq_pkg::ST_TICK_SCAN: begin
            if (!status.scan_busy && !status.found) begin
               cmd.scan_start = 1'b1;
               cmd.scan_sel   = otq_pkg::SCAN_USED;
            end
         end
         otq_pkg::ST_FIRE: begin
            if (status.out_free) begin
               cmd.emit       = otq_pkg::EMIT_FIRE;
               cmd.scan_start = 1'b1;
               cmd.scan_sel   = otq_pkg::SCAN_DUE;
            end
         end
         otq_pkg::ST_SUM_CALC: begin
            cmd.sum_calc = 1'b1;
         end
         otq_pkg::ST_SUM_EMIT: begin
            if (status.out_free) begin
               cmd.emit = otq_pkg::EMIT_SUM;
            end
         end
         default: begin
            cmd = cmd;
         end
      endcase
   end

endmodule

`default_nettype wire

[rtl/otq_datapath.sv]
`default_nettype none

module otq_datapath #(
   parameter int TIMER_SLOTS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire otq_pkg::otq_req_type                req_data,
   input  wire otq_pkg::otq_cmd_type                cmd,
   input  wire logic                                csr_we,
   input  wire logic [otq_pkg::MIN_LEAD_W-1:0]      csr_data,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_valid,
   output otq_pkg::otq_rsp_type                     rsp_data,
   output otq_pkg::otq_status_type                  status
);

   localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TIMER_SLOTS - 1);
   localparam int TW = otq_pkg::TIME_W;
   localparam int PW = otq_pkg::PERIOD_W;

   // Timer storage.
   logic [TW-1:0]          dl_mem_ff  [TIMER_SLOTS];
   logic [PW-1:0]          per_mem_ff [TIMER_SLOTS];
   logic [TIMER_SLOTS-1:0] used_ff;
   logic [TIMER_SLOTS-1:0] due_ff;

   // Captured item and register.
   logic [TW-1:0]                  expire_ff, now_ff;
   logic [PW-1:0]                  period_ff;
   logic [otq_pkg::MIN_LEAD_W-1:0] min_lead_ff;
   logic [SLOT_W-1:0]              free_idx_ff;
   logic                           full_ff;

   // Scan pipeline.
   logic                      scan_run_ff;
   logic [SLOT_W-1:0]         scan_addr_ff;
   otq_pkg::otq_scan_sel_type scan_sel_ff;
   logic                      rd_vld_ff;
   logic [SLOT_W-1:0]         rd_idx_ff;
   logic [TW-1:0]             rd_dl_ff;
   logic [PW-1:0]             rd_per_ff;
   logic                      best_found_ff;
   logic [SLOT_W-1:0]         best_idx_ff;
   logic [TW-1:0]             best_dl_ff;

   // Arithmetic results.
   logic [TW-1:0] diff_ff;
   logic          changed_ff;
   logic [TW-1:0] newmin_ff;

   logic                 rsp_valid_ff;
   otq_pkg::otq_rsp_type rsp_data_ff, rsp_data_in;

   logic              out_free;
   logic [SLOT_W-1:0] free_idx;
   logic              free_none;
   logic              rd_late;
   logic              cand;
   logic              better;
   logic [TW:0]       reload_sum;
   logic [TW-1:0]     reload_dl;
   logic [TW-1:0]     diff_src;
   logic [TW:0]       diff_full;
   logic [TW-1:0]     lead_ext;
   logic [TW-1:0]     lead_max;
   logic              dl_we;
   logic [SLOT_W-1:0] dl_waddr;
   logic [TW-1:0]     dl_wdata;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      free_idx  = '0;
      free_none = 1'b1;
      for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_idx  = SLOT_W'(i);
            free_none = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         expire_ff   <= req_data.expire_at;
         period_ff   <= req_data.period_us;
         now_ff      <= req_data.now_us;
         free_idx_ff <= free_idx;
         full_ff     <= free_none;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_lead_ff <= otq_pkg::MIN_LEAD_RESET;
      end else if (csr_we) begin
         min_lead_ff <= csr_data;
      end
   end

   // Reload of a fired periodic timer saturates at the top of the time range.
   assign reload_sum = {1'b0, now_ff} + {{(TW + 1 - PW){1'b0}}, rd_per_ff};
   assign reload_dl  = reload_sum[TW] ? {TW{1'b1}} : reload_sum[TW-1:0];

   always_comb begin
      dl_we    = 1'b0;
      dl_waddr = best_idx_ff;
      dl_wdata = reload_dl;
      if (cmd.add_commit) begin
         dl_we    = 1'b1;
         dl_waddr = free_idx_ff;
         dl_wdata = expire_ff;
      end else if (cmd.emit == otq_pkg::EMIT_FIRE && rd_per_ff != '0) begin
         dl_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (dl_we) begin
         dl_mem_ff[dl_waddr] <= dl_wdata;
      end
      rd_dl_ff <= dl_mem_ff[scan_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.add_commit) begin
         per_mem_ff[free_idx_ff] <= period_ff;
      end
      rd_per_ff <= per_mem_ff[best_idx_ff];
   end

   // Scan address stage: one slot read per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_run_ff  <= 1'b0;
         scan_addr_ff <= '0;
         rd_vld_ff    <= 1'b0;
         scan_sel_ff  <= otq_pkg::SCAN_USED;
      end else begin
         rd_vld_ff <= scan_run_ff;
         if (cmd.scan_start) begin
            scan_run_ff  <= 1'b1;
            scan_addr_ff <= '0;
            scan_sel_ff  <= cmd.scan_sel;
         end else if (scan_run_ff) begin
            if (scan_addr_ff == LAST_SLOT) begin
               scan_run_ff <= 1'b0;
            end else begin
               scan_addr_ff <= scan_addr_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= scan_addr_ff;
   end

   // Compare stage: strict less-than in ascending slot order keeps the
   // lower slot on equal deadlines.
   assign rd_late = rd_dl_ff > now_ff;

   always_comb begin
      case (scan_sel_ff)
         otq_pkg::SCAN_USED: cand = used_ff[rd_idx_ff];
         otq_pkg::SCAN_MARK: cand = used_ff[rd_idx_ff] && !rd_late;
         otq_pkg::SCAN_DUE:  cand = due_ff[rd_idx_ff];
         default:            cand = 1'b0;
      endcase
   end

   assign better = rd_vld_ff && cand && (!best_found_ff || rd_dl_ff < best_dl_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         best_found_ff <= 1'b0;
      end else if (cmd.scan_start) begin
         best_found_ff <= 1'b0;
      end else if (better) begin
         best_found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (better) begin
         best_idx_ff <= rd_idx_ff;
         best_dl_ff  <= rd_dl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         due_ff  <= '0;
      end else begin
         if (rd_vld_ff && scan_sel_ff == otq_pkg::SCAN_MARK) begin
            due_ff[rd_idx_ff] <= used_ff[rd_idx_ff] && !rd_late;
         end
         if (cmd.add_commit) begin
            used_ff[free_idx_ff] <= 1'b1;
         end
         if (cmd.emit == otq_pkg::EMIT_FIRE) begin
            due_ff[best_idx_ff] <= 1'b0;
            if (rd_per_ff == '0) begin
               used_ff[best_idx_ff] <= 1'b0;
            end
         end
      end
   end

   // Delay to the deadline, clamped at zero; the minimum lead is applied
   // on the way into the result register.
   assign diff_src  = cmd.add_commit ? expire_ff : best_dl_ff;
   assign diff_full = {1'b0, diff_src} - {1'b0, now_ff};

   always_ff @(posedge clock) begin
      if (cmd.add_commit || cmd.sum_calc) begin
         diff_ff <= diff_full[TW] ? '0 : diff_full[TW-1:0];
      end
      if (cmd.add_commit) begin
         changed_ff <= !best_found_ff || (expire_ff < best_dl_ff);
         newmin_ff  <= (!best_found_ff || (expire_ff < best_dl_ff)) ? expire_ff
                                                                     : best_dl_ff;
      end
   end

   assign lead_ext = {{(TW - otq_pkg::MIN_LEAD_W){1'b0}}, min_lead_ff};
   assign lead_max = (diff_ff < lead_ext) ? lead_ext : diff_ff;

   always_comb begin
      rsp_data_in = '0;
      case (cmd.emit)
         otq_pkg::EMIT_ADD: begin
            rsp_data_in.kind          = otq_pkg::KIND_ADDED;
            rsp_data_in.handle        = otq_pkg::HANDLE_W'(free_idx_ff);
            rsp_data_in.arm_valid     = changed_ff;
            rsp_data_in.arm_delay_us  = changed_ff ? lead_max : '0;
            rsp_data_in.next_deadline = newmin_ff;
            rsp_data_in.last          = 1'b1;
         end
         otq_pkg::EMIT_FULL: begin
            rsp_data_in.kind          = otq_pkg::KIND_FULL;
            rsp_data_in.next_deadline = best_found_ff ? best_dl_ff : '0;
            rsp_data_in.last          = 1'b1;
         end
         otq_pkg::EMIT_FIRE: begin
            rsp_data_in.kind   = otq_pkg::KIND_FIRED;
            rsp_data_in.handle = otq_pkg::HANDLE_W'(best_idx_ff);
         end
         otq_pkg::EMIT_SUM: begin
            rsp_data_in.kind          = otq_pkg::KIND_SUMMARY;
            rsp_data_in.arm_valid     = best_found_ff;
            rsp_data_in.arm_delay_us  = best_found_ff ? lead_max : '0;
            rsp_data_in.next_deadline = best_found_ff ? best_dl_ff : '0;
            rsp_data_in.last          = 1'b1;
         end
         default: begin
            rsp_data_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit != otq_pkg::EMIT_NONE) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit != otq_pkg::EMIT_NONE) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_data_ff;
   assign status.scan_busy = scan_run_ff || rd_vld_ff;
   assign status.found     = best_found_ff;
   assign status.full      = full_ff;
   assign status.out_free  = out_free;

`ifndef ASSERT_OFF
   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit != otq_pkg::EMIT_NONE |-> out_free)
      else $error("result loaded while the output register is still held");

   a_fire_is_due: assert property (@(posedge clock) disable iff (reset)
      cmd.emit == otq_pkg::EMIT_FIRE |-> used_ff[best_idx_ff] && due_ff[best_idx_ff])
      else $error("fired a slot that is not a due timer");

   a_fire_clears_due: assert property (@(posedge clock) disable iff (reset)
      cmd.emit == otq_pkg::EMIT_FIRE |=> !due_ff[$past(best_idx_ff)])
      else $error("fired timer still marked due");

   a_commit_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.add_commit |-> !full_ff && !used_ff[free_idx_ff])
      else $error("add written into an occupied slot");

   a_scan_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_start |-> !scan_run_ff && !rd_vld_ff)
      else $error("scan restarted while a scan is in flight");
`endif

endmodule

`default_nettype wire

[rtl/ordered_timer_queue.sv]
`default_nettype none

// Ordered timer queue: a store of TIMER_SLOTS timers, each an absolute
// deadline and a repeat period in microseconds. A request beat with mode 0
// adds a timer in the lowest free slot and answers with one beat giving the
// handle, whether the earliest deadline moved (and then the arm delay), and
// the new earliest deadline; a full store answers with a store-full beat.
// A request beat with mode 1 is a tick at now_us: every timer due at or
// before now_us fires, in deadline order with ties to the lower slot, one
// response beat per fired timer, periodic timers reload to now_us plus
// period (saturating), one-shot timers are freed, and a closing summary beat
// gives the next deadline and, if a timer is left, an arm delay of at least
// min_lead_us. The last field marks the closing beat of each request. The
// block works on one request at a time and holds req_stall high until its
// closing beat is in the output register. Every search for the earliest
// deadline is a scan through the deadline memory at one slot per cycle.
// The min_lead_us register is written through the csr port, which is always
// ready and is meant to be written while the queue is idle.

module ordered_timer_queue #(
   parameter int TIMER_SLOTS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire otq_pkg::otq_req_type           req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output otq_pkg::otq_rsp_type                rsp_data,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [otq_pkg::MIN_LEAD_W-1:0] csr_data
);

   otq_pkg::otq_cmd_type    cmd;
   otq_pkg::otq_status_type status;

   // The single register can be taken on any cycle.
   assign csr_ready = 1'b1;

   // The controller sequences the scans, fires and result beats.
   otq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_data.mode),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the timer memories, the scan unit, the delay
   // arithmetic and the output register.
   otq_datapath #(
      .TIMER_SLOTS (TIMER_SLOTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .csr_we    (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .status    (status)
   );

endmodule

`default_nettype wire
